// ===== rtl/cccu_pkg.sv =====
// Shared types, constants and calendar helper functions for the calendar clock counter.
// Used by all modules of the block; no dependencies.
`default_nettype none

package cccu_pkg;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_HOUR_UP   = 2'd1,
        CMD_HOUR_DOWN = 2'd2,
        CMD_LOAD      = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_cal;

    typedef struct packed {
        t_cmd cmd;
        t_cal load;
    } t_in_item;

    localparam logic [5:0] SEC_LIMIT  = 6'd60;
    localparam logic [5:0] MIN_LIMIT  = 6'd60;
    localparam logic [4:0] HOUR_LIMIT = 5'd24;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [6:0] YEAR_MAX   = 7'd99;
    localparam logic [4:0] FEB_LEAP   = 5'd29;
    localparam logic [4:0] FEB_PLAIN  = 5'd28;

    localparam t_cal CAL_RESET = '{sec: 6'd0, min: 6'd0, hour: 5'd0,
                                   day: 5'd1, month: 4'd1, year: 7'd0};

    // Month length; out-of-range months read as January.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] n;
        case (month)
            4'd2: begin
                n = (year[1:0] == 2'b00) ? FEB_LEAP : FEB_PLAIN;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                n = 5'd30;
            end
            default: begin
                n = 5'd31;
            end
        endcase
        return n;
    endfunction

    function automatic logic [2:0] carroll(input logic [3:0] month);
        logic [2:0] v;
        case (month)
            4'd1:    v = 3'd0;
            4'd2:    v = 3'd3;
            4'd3:    v = 3'd3;
            4'd4:    v = 3'd6;
            4'd5:    v = 3'd1;
            4'd6:    v = 3'd4;
            4'd7:    v = 3'd6;
            4'd8:    v = 3'd2;
            4'd9:    v = 3'd5;
            4'd10:   v = 3'd0;
            4'd11:   v = 3'd3;
            4'd12:   v = 3'd5;
            default: v = 3'd0;
        endcase
        return v;
    endfunction

    // x mod 7 by reciprocal multiply, exact for x up to 70.
    function automatic logic [2:0] mod7(input logic [6:0] x);
        logic [12:0] p;
        logic [6:0]  q;
        p = {6'd0, x} * 13'd37;
        q = {2'd0, p[12:8]};
        return 3'(x - q * 7'd7);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/calendar_clock_counter_unit.sv =====
// Calendar clock counter top level: input stage, time/date state, weekday output.
// Depends on cccu_pkg, cccu_in_stage, cccu_cal_next, cccu_weekday.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------------
//  command | i_valid / o_stall   | i_cmd, i_load_seconds .. i_load_year
//  result  | o_valid / i_stall   | o_seconds, o_minutes, o_hours, o_day, o_month,
//          |                     | o_year, o_weekday
//
// One transaction per cycle sustained while i_stall stays low; a command passes through
// the input register, then the time/date registers that drive the result ports.
// The time/date registers update when a command moves out of the input register,
// which happens whenever the result slot is empty or being taken.
// Reset (synchronous, active low) gives 00:00:00 on 2000-01-01 and empty stages.
// o_stall rises only when the input register is full and the result is stalled.
`default_nettype none

module calendar_clock_counter_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_cmd,
    input  wire logic [5:0] i_load_seconds,
    input  wire logic [5:0] i_load_minutes,
    input  wire logic [4:0] i_load_hours,
    input  wire logic [4:0] i_load_day,
    input  wire logic [3:0] i_load_month,
    input  wire logic [6:0] i_load_year,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [5:0]      o_seconds,
    output logic [5:0]      o_minutes,
    output logic [4:0]      o_hours,
    output logic [4:0]      o_day,
    output logic [3:0]      o_month,
    output logic [6:0]      o_year,
    output logic [2:0]      o_weekday
);
    import cccu_pkg::*;

    t_cal     w_load;
    t_in_item w_item;
    logic     w_item_valid;
    logic     w_take;
    t_cal     r_cal;
    t_cal     n_cal;
    logic     r_out_valid;
    logic     n_out_valid;

    assign w_load = '{sec: i_load_seconds, min: i_load_minutes, hour: i_load_hours,
                      day: i_load_day, month: i_load_month, year: i_load_year};

    assign w_take = w_item_valid && !(r_out_valid && i_stall);

    cccu_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_load       (w_load),
        .i_take       (w_take),
        .o_item_valid (w_item_valid),
        .o_item       (w_item)
    );

    cccu_cal_next u_next (
        .i_cur  (r_cal),
        .i_item (w_item),
        .o_nxt  (n_cal)
    );

    always_comb begin
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal       <= CAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_cal <= n_cal;
            end
        end
    end

    cccu_weekday u_wday (
        .i_cal     (r_cal),
        .o_weekday (o_weekday)
    );

    assign o_valid   = r_out_valid;
    assign o_seconds = r_cal.sec;
    assign o_minutes = r_cal.min;
    assign o_hours   = r_cal.hour;
    assign o_day     = r_cal.day;
    assign o_month   = r_cal.month;
    assign o_year    = r_cal.year;

`ifndef SYNTHESIS
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal.sec < SEC_LIMIT && r_cal.min < MIN_LIMIT && r_cal.hour < HOUR_LIMIT)
        else $error("time field out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal.month >= 4'd1 && r_cal.month <= MONTH_LAST && r_cal.year <= YEAR_MAX &&
        r_cal.day >= 5'd1 && r_cal.day <= days_in(r_cal.month, r_cal.year))
        else $error("date field out of range");

    a_weekday_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_weekday < 3'd7)
        else $error("weekday out of range");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_take |=> $stable(r_cal))
        else $error("time/date changed without a transaction");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_take)
        else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

// ===== rtl/cccu_in_stage.sv =====
// Input register stage: captures one command transaction and holds it until taken.
// Depends on cccu_pkg.
`default_nettype none

module cccu_in_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire cccu_pkg::t_cal    i_load,
    input  wire logic              i_take,
    output logic                   o_item_valid,
    output cccu_pkg::t_in_item     o_item
);
    import cccu_pkg::*;

    logic     r_valid;
    logic     n_valid;
    t_in_item r_item;
    logic     w_accept;

    assign o_stall  = r_valid && !i_take;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.cmd  <= t_cmd'(i_cmd);
            r_item.load <= i_load;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

`default_nettype wire

// ===== rtl/cccu_cal_next.sv =====
// Next-state logic for time and date: tick, hour advance, hour retreat, clamped load.
// Depends on cccu_pkg.
`default_nettype none

module cccu_cal_next (
    input  wire cccu_pkg::t_cal i_cur,
    input  wire cccu_pkg::t_in_item i_item,
    output cccu_pkg::t_cal o_nxt
);
    import cccu_pkg::*;

    t_cal       w_fwd;
    t_cal       w_back;
    t_cal       w_ld;
    logic [3:0] w_bmonth;
    logic [6:0] w_byear;

    // one day forward, time fields untouched
    always_comb begin
        w_fwd = i_cur;
        if (i_cur.day >= days_in(i_cur.month, i_cur.year)) begin
            w_fwd.day = 5'd1;
            if (i_cur.month >= MONTH_LAST) begin
                w_fwd.month = 4'd1;
                w_fwd.year  = (i_cur.year >= YEAR_MAX) ? 7'd0 : i_cur.year + 7'd1;
            end else begin
                w_fwd.month = i_cur.month + 4'd1;
            end
        end else begin
            w_fwd.day = i_cur.day + 5'd1;
        end
    end

    // one day back
    always_comb begin
        w_back = i_cur;
        if (i_cur.month <= 4'd1) begin
            w_bmonth = MONTH_LAST;
            w_byear  = (i_cur.year == 7'd0) ? YEAR_MAX : i_cur.year - 7'd1;
        end else begin
            w_bmonth = i_cur.month - 4'd1;
            w_byear  = i_cur.year;
        end
        if (i_cur.day <= 5'd1) begin
            w_back.month = w_bmonth;
            w_back.year  = w_byear;
            w_back.day   = days_in(w_bmonth, w_byear);
        end else begin
            w_back.day = i_cur.day - 5'd1;
        end
    end

    always_comb begin
        w_ld.sec   = (i_item.load.sec  >= SEC_LIMIT)  ? 6'd0 : i_item.load.sec;
        w_ld.min   = (i_item.load.min  >= MIN_LIMIT)  ? 6'd0 : i_item.load.min;
        w_ld.hour  = (i_item.load.hour >= HOUR_LIMIT) ? 5'd0 : i_item.load.hour;
        w_ld.month = (i_item.load.month == 4'd0 || i_item.load.month > MONTH_LAST)
                     ? 4'd1 : i_item.load.month;
        w_ld.year  = (i_item.load.year > YEAR_MAX) ? 7'd0 : i_item.load.year;
        w_ld.day   = (i_item.load.day == 5'd0 ||
                      i_item.load.day > days_in(w_ld.month, w_ld.year))
                     ? 5'd1 : i_item.load.day;
    end

    always_comb begin
        o_nxt = i_cur;
        case (i_item.cmd)
            CMD_TICK: begin
                if (i_cur.sec >= SEC_LIMIT - 6'd1) begin
                    o_nxt.sec = 6'd0;
                    if (i_cur.min >= MIN_LIMIT - 6'd1) begin
                        o_nxt.min = 6'd0;
                        if (i_cur.hour >= HOUR_LAST) begin
                            o_nxt      = w_fwd;
                            o_nxt.sec  = 6'd0;
                            o_nxt.min  = 6'd0;
                            o_nxt.hour = 5'd0;
                        end else begin
                            o_nxt.hour = i_cur.hour + 5'd1;
                        end
                    end else begin
                        o_nxt.min = i_cur.min + 6'd1;
                    end
                end else begin
                    o_nxt.sec = i_cur.sec + 6'd1;
                end
            end
            CMD_HOUR_UP: begin
                if (i_cur.hour >= HOUR_LAST) begin
                    o_nxt      = w_fwd;
                    o_nxt.hour = 5'd0;
                end else begin
                    o_nxt.hour = i_cur.hour + 5'd1;
                end
            end
            CMD_HOUR_DOWN: begin
                if (i_cur.hour == 5'd0) begin
                    o_nxt      = w_back;
                    o_nxt.hour = HOUR_LAST;
                end else begin
                    o_nxt.hour = i_cur.hour - 5'd1;
                end
            end
            CMD_LOAD: begin
                o_nxt = w_ld;
            end
            default: begin
                o_nxt = i_cur;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/cccu_weekday.sv =====
// Weekday of the current date by the Carroll method, 0 is Sunday.
// Depends on cccu_pkg.
`default_nettype none

module cccu_weekday (
    input  wire cccu_pkg::t_cal i_cal,
    output logic [2:0]          o_weekday
);
    import cccu_pkg::*;

    logic [14:0] w_prod;
    logic [3:0]  w_q12;
    logic [3:0]  w_r12;
    logic [4:0]  w_day;
    logic [6:0]  w_sum;

    // year / 12 via 171/2048, exact for year up to 99
    assign w_prod = {8'd0, i_cal.year} * 15'd171;
    assign w_q12  = w_prod[14:11];
    assign w_r12  = 4'(i_cal.year - {3'd0, w_q12} * 7'd12);

    always_comb begin
        w_day = i_cal.day;
        if (i_cal.year[1:0] == 2'b00 && (i_cal.month == 4'd1 || i_cal.month == 4'd2)
            && i_cal.day != 5'd0) begin
            w_day = i_cal.day - 5'd1;
        end
    end

    assign w_sum = 7'd6 + {3'd0, w_q12} + {3'd0, w_r12} + {5'd0, w_r12[3:2]}
                 + {4'd0, carroll(i_cal.month)} + {2'd0, w_day};

    assign o_weekday = mod7(w_sum);

endmodule

`default_nettype wire

// ===== sim/tb_calendar_clock_counter_unit.sv =====
// Testbench for calendar_clock_counter_unit: directed table, then random command
// sequences, with a built-in clock/calendar predictor and randomized flow control.
// Depends on cccu_pkg and the calendar_clock_counter_unit RTL.
module tb_calendar_clock_counter_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import cccu_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 60;

    typedef struct packed {
        t_cal       cal;
        logic [2:0] wday;
    } clock_reading_t;

    typedef struct {
        t_cmd           cmd;
        t_cal           load;
        bit             pinned;
        clock_reading_t want;
    } dir_row_t;

    localparam byte unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    localparam byte unsigned CARROLL_OFS[12] = '{0, 3, 3, 6, 1, 4, 6, 2, 5, 0, 3, 5};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [1:0] i_cmd;
    logic [5:0] i_load_seconds;
    logic [5:0] i_load_minutes;
    logic [4:0] i_load_hours;
    logic [4:0] i_load_day;
    logic [3:0] i_load_month;
    logic [6:0] i_load_year;
    logic       o_valid;
    logic       i_stall;
    logic [5:0] o_seconds;
    logic [5:0] o_minutes;
    logic [4:0] o_hours;
    logic [4:0] o_day;
    logic [3:0] o_month;
    logic [6:0] o_year;
    logic [2:0] o_weekday;

    t_cal           clock_now;
    clock_reading_t readings_due[$];
    dir_row_t       plan[$];
    int             mismatch_count = 0;
    bit             quiet = 1'b0;
    bit             hold_req = 1'b0;

    calendar_clock_counter_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cmd          (i_cmd),
        .i_load_seconds (i_load_seconds),
        .i_load_minutes (i_load_minutes),
        .i_load_hours   (i_load_hours),
        .i_load_day     (i_load_day),
        .i_load_month   (i_load_month),
        .i_load_year    (i_load_year),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_seconds      (o_seconds),
        .o_minutes      (o_minutes),
        .o_hours        (o_hours),
        .o_day          (o_day),
        .o_month        (o_month),
        .o_year         (o_year),
        .o_weekday      (o_weekday)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- calendar predictor ----------------

    function automatic int month_idx(logic [3:0] mo);
        return (mo >= 1 && mo <= 12) ? int'(mo) - 1 : 0;
    endfunction

    function automatic int month_length(logic [3:0] mo, logic [6:0] yr);
        int n;
        n = MONTH_DAYS[month_idx(mo)];
        if (n == 28 && yr % 4 == 0) n = 29;
        return n;
    endfunction

    function automatic logic [2:0] weekday_for(t_cal c);
        int y;
        int r;
        int v;
        int x;
        y = c.year;
        r = y % 12;
        v = (6 + y / 12 + r + r / 4) % 7;
        v = (v + CARROLL_OFS[month_idx(c.month)]) % 7;
        x = c.day;
        if (y % 4 == 0 && (c.month == 1 || c.month == 2) && x > 0) x--;
        return 3'((v + x) % 7);
    endfunction

    function automatic void next_day();
        if (clock_now.day + 1 > month_length(clock_now.month, clock_now.year)) begin
            clock_now.day = 5'd1;
            if (clock_now.month == 12) begin
                clock_now.month = 4'd1;
                clock_now.year = (clock_now.year >= 99) ? 7'd0 : clock_now.year + 7'd1;
            end else begin
                clock_now.month = clock_now.month + 4'd1;
            end
        end else begin
            clock_now.day = clock_now.day + 5'd1;
        end
    endfunction

    function automatic void prev_day();
        if (clock_now.day <= 1) begin
            if (clock_now.month <= 1) begin
                clock_now.month = 4'd12;
                clock_now.year = (clock_now.year == 0) ? 7'd99 : clock_now.year - 7'd1;
            end else begin
                clock_now.month = clock_now.month - 4'd1;
            end
            clock_now.day = 5'(month_length(clock_now.month, clock_now.year));
        end else begin
            clock_now.day = clock_now.day - 5'd1;
        end
    endfunction

    function automatic clock_reading_t advance_clock(t_cmd cmd, t_cal ld);
        clock_reading_t r;
        t_cal c;
        case (cmd)
            CMD_TICK: begin
                if (clock_now.sec >= 59) begin
                    clock_now.sec = 6'd0;
                    if (clock_now.min >= 59) begin
                        clock_now.min = 6'd0;
                        if (clock_now.hour >= 23) begin
                            clock_now.hour = 5'd0;
                            next_day();
                        end else begin
                            clock_now.hour = clock_now.hour + 5'd1;
                        end
                    end else begin
                        clock_now.min = clock_now.min + 6'd1;
                    end
                end else begin
                    clock_now.sec = clock_now.sec + 6'd1;
                end
            end
            CMD_HOUR_UP: begin
                if (clock_now.hour >= 23) begin
                    clock_now.hour = 5'd0;
                    next_day();
                end else begin
                    clock_now.hour = clock_now.hour + 5'd1;
                end
            end
            CMD_HOUR_DOWN: begin
                if (clock_now.hour == 0) begin
                    clock_now.hour = 5'd23;
                    prev_day();
                end else begin
                    clock_now.hour = clock_now.hour - 5'd1;
                end
            end
            default: begin
                c = ld;
                if (c.sec >= 60) c.sec = 6'd0;
                if (c.min >= 60) c.min = 6'd0;
                if (c.hour >= 24) c.hour = 5'd0;
                if (c.month == 0 || c.month > 12) c.month = 4'd1;
                if (c.year > 99) c.year = 7'd0;
                if (c.day == 0 || c.day > month_length(c.month, c.year)) c.day = 5'd1;
                clock_now = c;
            end
        endcase
        r.cal = clock_now;
        r.wday = weekday_for(clock_now);
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_cal cal_of(int s, int mi, int h, int d, int mo, int y);
        t_cal c;
        c.sec = 6'(s);
        c.min = 6'(mi);
        c.hour = 5'(h);
        c.day = 5'(d);
        c.month = 4'(mo);
        c.year = 7'(y);
        return c;
    endfunction

    function automatic void row(t_cmd cmd, int s, int mi, int h, int d, int mo, int y);
        dir_row_t r;
        r.cmd = cmd;
        r.load = cal_of(s, mi, h, d, mo, y);
        r.pinned = 1'b0;
        r.want = '0;
        plan.push_back(r);
    endfunction

    function automatic void pin(int s, int mi, int h, int d, int mo, int y, int wd);
        plan[plan.size() - 1].pinned = 1'b1;
        plan[plan.size() - 1].want.cal = cal_of(s, mi, h, d, mo, y);
        plan[plan.size() - 1].want.wday = 3'(wd);
    endfunction

    function automatic t_cal random_load();
        return cal_of($urandom_range(63), $urandom_range(63), $urandom_range(31),
                      $urandom_range(31), $urandom_range(15), $urandom_range(127));
    endfunction

    // loads that sit just short of a carry or borrow
    function automatic t_cal near_rollover_load();
        t_cal c;
        int k;
        c.sec = 6'($urandom_range(59, 54));
        c.min = ($urandom_range(1) != 0) ? 6'd59 : 6'($urandom_range(59));
        k = $urandom_range(5);
        c.hour = (k < 2) ? 5'd23 : (k == 2) ? 5'd0 : (k == 3) ? 5'd1 : 5'($urandom_range(23));
        k = $urandom_range(3);
        c.month = (k == 0) ? 4'd2 : (k == 1) ? 4'd12 : 4'($urandom_range(12, 1));
        k = $urandom_range(9);
        c.year = (k < 3) ? 7'd99 : (k < 5) ? 7'd0 : 7'($urandom_range(99));
        k = $urandom_range(9);
        c.day = (k < 5) ? 5'(month_length(c.month, c.year)) :
                (k < 7) ? 5'd1 : 5'($urandom_range(31, 1));
        return c;
    endfunction

    function automatic t_cmd pick_step_cmd();
        int r;
        r = $urandom_range(99);
        return (r < 60) ? CMD_TICK : (r < 80) ? CMD_HOUR_UP : CMD_HOUR_DOWN;
    endfunction

    task automatic send_cmd(t_cmd cmd, t_cal ld, bit pinned, clock_reading_t want);
        clock_reading_t got;
        if (!quiet && $urandom_range(99) < 30) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_load_seconds <= ld.sec;
        i_load_minutes <= ld.min;
        i_load_hours   <= ld.hour;
        i_load_day     <= ld.day;
        i_load_month   <= ld.month;
        i_load_year    <= ld.year;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = advance_clock(cmd, ld);
        readings_due.push_back(pinned ? want : got);
    endtask

    task automatic run_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 15) begin
                send_cmd(t_cmd'($urandom_range(3)), random_load(), 1'b0, '0);
                sent++;
            end else begin
                send_cmd(CMD_LOAD, near_rollover_load(), 1'b0, '0);
                sent++;
                repeat ($urandom_range(8, 1)) begin
                    send_cmd(pick_step_cmd(), random_load(), 1'b0, '0);
                    sent++;
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (readings_due.size() != 0) @(posedge i_clk);
    endtask

    // ---------------- result side ----------------

    initial begin : result_flow
        int hold_left;
        hold_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (quiet) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 30);
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        clock_reading_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (readings_due.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end else begin
                want = readings_due.pop_front();
                check_field("seconds", want.cal.sec, o_seconds);
                check_field("minutes", want.cal.min, o_minutes);
                check_field("hours", want.cal.hour, o_hours);
                check_field("day", want.cal.day, o_day);
                check_field("month", want.cal.month, o_month);
                check_field("year", want.cal.year, o_year);
                check_field("weekday", want.wday, o_weekday);
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("tb_calendar_clock_counter_unit: FAIL");
                $finish;
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin : main_flow
        clock_now = CAL_RESET;
        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_cmd          <= CMD_TICK;
        i_load_seconds <= '0;
        i_load_minutes <= '0;
        i_load_hours   <= '0;
        i_load_day     <= '0;
        i_load_month   <= '0;
        i_load_year    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        row(CMD_TICK,      0,  0,  0,  0,  0,   0); pin(1, 0, 0, 1, 1, 0, 6);
        row(CMD_LOAD,     63, 63, 31, 31, 15, 127); pin(0, 0, 0, 31, 1, 0, 1);
        row(CMD_LOAD,      0,  0,  0,  0,  0,   0); pin(0, 0, 0, 1, 1, 0, 6);
        row(CMD_LOAD,     59, 59, 23, 31, 12,  99);
        row(CMD_TICK,      0,  0,  0,  0,  0,   0);
        row(CMD_LOAD,     15, 30, 23, 28,  2,   0);
        row(CMD_HOUR_UP,   0,  0,  0,  0,  0,   0);
        row(CMD_HOUR_UP,  63, 63, 31, 31, 15, 127);
        row(CMD_HOUR_DOWN, 0,  0,  0,  0,  0,   0);
        row(CMD_HOUR_DOWN, 0,  0,  0,  0,  0,   0);
        row(CMD_LOAD,     20, 10,  0,  1,  1,   0);
        row(CMD_HOUR_DOWN, 0,  0,  0,  0,  0,   0);
        row(CMD_TICK,      0,  0,  0,  0,  0,   0);
        row(CMD_LOAD,     45, 30, 12, 29,  2,   1); pin(45, 30, 12, 1, 2, 1, 4);
        row(CMD_LOAD,      0,  0,  0, 31,  4,   5);
        row(CMD_LOAD,     59, 59, 23, 29,  2,   4);
        row(CMD_TICK,      0,  0,  0,  0,  0,   0);
        row(CMD_LOAD,     60, 60, 24, 15, 13, 100); pin(0, 0, 0, 15, 1, 0, 6);
        row(CMD_LOAD,      5,  5,  0,  1,  3,   1);
        row(CMD_HOUR_DOWN, 0,  0,  0,  0,  0,   0);
        row(CMD_LOAD,      0,  0, 23, 31, 12,  99);
        row(CMD_HOUR_UP,   0,  0,  0,  0,  0,   0);
        row(CMD_LOAD,     58, 59, 23, 30,  6,  50);
        row(CMD_TICK,      0,  0,  0,  0,  0,   0);
        row(CMD_TICK,      0,  0,  0,  0,  0,   0);

        foreach (plan[k])
            send_cmd(plan[k].cmd, plan[k].load, plan[k].pinned, plan[k].want);

        run_random(600);

        // receiver holds off while the sender keeps offering back to back
        quiet = 1'b1;
        hold_req = 1'b1;
        run_random(40);
        i_valid <= 1'b0;
        wait_drained();

        run_random(300);
        quiet = 1'b0;
        run_random(460);

        i_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_calendar_clock_counter_unit: PASS");
        end else begin
            $display("tb_calendar_clock_counter_unit: FAIL");
        end
        $finish;
    end

endmodule
